>>> design/tqp_pkg.sv
// Shared constants for the quote parser: format words, result kinds, error codes.
`timescale 1ns / 1ps

package tqp_pkg;

  // Quote format
  localparam logic [31:0] MAGIC_WORD     = 32'hFF54_4347;
  localparam logic [15:0] QUOTE_TYPE     = 16'h8018;
  localparam logic [15:0] CLOCK_BYTES    = 16'd17;
  localparam logic [4:0]  MAX_SELECTIONS = 5'd16;
  localparam logic [4:0]  LIMIT_RESET    = 5'd16;

  // Result kinds
  localparam logic [2:0] KIND_NONCE  = 3'd0;
  localparam logic [2:0] KIND_DIGEST = 3'd1;
  localparam logic [2:0] KIND_HASH   = 3'd2;
  localparam logic [2:0] KIND_PCR    = 3'd3;
  localparam logic [2:0] KIND_FW     = 3'd4;
  localparam logic [2:0] KIND_DONE   = 3'd5;
  localparam logic [2:0] KIND_ERROR  = 3'd6;

  // Error codes
  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_MAGIC   = 3'd1;
  localparam logic [2:0] ERR_TYPE    = 3'd2;
  localparam logic [2:0] ERR_COUNT   = 3'd3;
  localparam logic [2:0] ERR_OVERRUN = 3'd4;

endpackage

>>> design/tpm_attest_quote_parser.sv
// Top level: byte-serial parser for a big-endian TPM2 quote attestation structure.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid/in_ready): one quote byte per item in data_byte,
//   end_of_quote high on the last byte of the buffer.
//   Output channel (out_valid/out_ready): one result per item in kind, value,
//   selection_index, error_code; last_of_run flags the final result of a byte.
//   cfg_wr_en/cfg_wr_data write selection_limit; write it only
//   while the parser is idle.
// Timing
//   A byte is parsed in the cycle it is accepted; its results sit in the
//   result register from the next cycle on. The register drains one result
//   per cycle while out_ready is high; a byte with n results holds it until
//   all n are taken (n is at most 9: a mask byte with all bits set plus an
//   overrun error). Bytes with zero or one result go at one per cycle while
//   out_ready is high; a byte that gives no result leaves the register empty.
//   in_ready is high when the register is empty or its last result is taken
//   in this cycle, so a stalled receiver stops the input after one byte.
// Reset
//   rst (synchronous) returns the parser to expecting the magic word, drops
//   any pending results and sets selection_limit to 16.

module tpm_attest_quote_parser (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_quote,
  // output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [63:0] value,
  output logic [3:0]  selection_index,
  output logic [2:0]  error_code,
  output logic        last_of_run,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data
);

  // Parse phases
  localparam logic [3:0] PH_MAGIC       = 4'd0;
  localparam logic [3:0] PH_TYPE        = 4'd1;
  localparam logic [3:0] PH_SIGNER_LEN  = 4'd2;
  localparam logic [3:0] PH_SIGNER_BODY = 4'd3;
  localparam logic [3:0] PH_NONCE_LEN   = 4'd4;
  localparam logic [3:0] PH_NONCE_BODY  = 4'd5;
  localparam logic [3:0] PH_CLOCK       = 4'd6;
  localparam logic [3:0] PH_FW          = 4'd7;
  localparam logic [3:0] PH_COUNT       = 4'd8;
  localparam logic [3:0] PH_HASH        = 4'd9;
  localparam logic [3:0] PH_SIZEOF      = 4'd10;
  localparam logic [3:0] PH_MASK        = 4'd11;
  localparam logic [3:0] PH_DIGEST_LEN  = 4'd12;
  localparam logic [3:0] PH_DIGEST_BODY = 4'd13;

  // Parser state
  logic [4:0]  selection_limit;
  logic [3:0]  phase, phase_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [63:0] acc, acc_next;
  logic [4:0]  sel_left, sel_left_next;
  logic [3:0]  cur_sel, cur_sel_next;
  logic [7:0]  mask_pos, mask_pos_next;
  logic        ignoring, ignoring_next;

  // Result register: head slot, PCR mask bits, tail slot
  logic        a_vld, a_vld_next;
  logic [2:0]  a_kind, a_kind_next;
  logic [63:0] a_value, a_value_next;
  logic [2:0]  a_err, a_err_next;
  logic [3:0]  r_sel, r_sel_next;
  logic [7:0]  r_mask, r_mask_next;
  logic [7:0]  r_pos, r_pos_next;
  logic        t_vld, t_vld_next;
  logic [2:0]  t_kind, t_kind_next;
  logic [2:0]  t_err, t_err_next;

  logic        in_fire, out_fire;
  logic [63:0] acc_raw;
  logic [15:0] left_dec;
  logic        whole;
  logic [15:0] len;
  logic [4:0]  sel_dec;
  logic [4:0]  limit_eff;
  logic [7:0]  mask_rest;
  logic [2:0]  mask_bit;

  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign limit_eff = (selection_limit > tqp_pkg::MAX_SELECTIONS) ?
                     tqp_pkg::MAX_SELECTIONS : selection_limit;

  // --------------------------------------------------------------------
  // Byte parse: next parser state and the results this byte produces
  // --------------------------------------------------------------------
  always_comb begin
    acc_raw  = {acc[55:0], data_byte};
    left_dec = (bytes_left != 16'd0) ? (bytes_left - 16'd1) : 16'd0;
    whole    = (left_dec == 16'd0);
    len      = acc_raw[15:0];
    sel_dec  = (sel_left != 5'd0) ? (sel_left - 5'd1) : 5'd0;

    phase_next      = phase;
    bytes_left_next = bytes_left;
    acc_next        = acc;
    sel_left_next   = sel_left;
    cur_sel_next    = cur_sel;
    mask_pos_next   = mask_pos;
    ignoring_next   = ignoring;

    a_vld_next   = 1'b0;
    a_kind_next  = tqp_pkg::KIND_NONCE;
    a_value_next = 64'd0;
    a_err_next   = tqp_pkg::ERR_NONE;
    r_sel_next   = 4'd0;
    r_mask_next  = 8'd0;
    r_pos_next   = mask_pos;
    t_vld_next   = 1'b0;
    t_kind_next  = tqp_pkg::KIND_DONE;
    t_err_next   = tqp_pkg::ERR_NONE;

    if (!ignoring) begin
      acc_next        = acc_raw;
      bytes_left_next = left_dec;
      case (phase)
        PH_MAGIC: begin
          if (whole) begin
            if (acc_raw[31:0] != tqp_pkg::MAGIC_WORD) begin
              a_vld_next    = 1'b1;
              a_kind_next   = tqp_pkg::KIND_ERROR;
              a_err_next    = tqp_pkg::ERR_MAGIC;
              ignoring_next = 1'b1;
            end else begin
              phase_next = PH_TYPE; bytes_left_next = 16'd2; acc_next = 64'd0;
            end
          end
        end
        PH_TYPE: begin
          if (whole) begin
            if (len != tqp_pkg::QUOTE_TYPE) begin
              a_vld_next    = 1'b1;
              a_kind_next   = tqp_pkg::KIND_ERROR;
              a_err_next    = tqp_pkg::ERR_TYPE;
              ignoring_next = 1'b1;
            end else begin
              phase_next = PH_SIGNER_LEN; bytes_left_next = 16'd2; acc_next = 64'd0;
            end
          end
        end
        PH_SIGNER_LEN: begin
          if (whole) begin
            acc_next = 64'd0;
            if (len != 16'd0) begin
              phase_next = PH_SIGNER_BODY; bytes_left_next = len;
            end else begin
              phase_next = PH_NONCE_LEN; bytes_left_next = 16'd2;
            end
          end
        end
        PH_SIGNER_BODY: begin
          if (whole) begin
            phase_next = PH_NONCE_LEN; bytes_left_next = 16'd2; acc_next = 64'd0;
          end
        end
        PH_NONCE_LEN: begin
          if (whole) begin
            acc_next = 64'd0;
            if (len != 16'd0) begin
              phase_next = PH_NONCE_BODY; bytes_left_next = len;
            end else begin
              phase_next = PH_CLOCK; bytes_left_next = tqp_pkg::CLOCK_BYTES;
            end
          end
        end
        PH_NONCE_BODY: begin
          a_vld_next   = 1'b1;
          a_kind_next  = tqp_pkg::KIND_NONCE;
          a_value_next = {56'd0, data_byte};
          if (whole) begin
            phase_next = PH_CLOCK; bytes_left_next = tqp_pkg::CLOCK_BYTES;
            acc_next   = 64'd0;
          end
        end
        PH_CLOCK: begin
          if (whole) begin
            phase_next = PH_FW; bytes_left_next = 16'd8; acc_next = 64'd0;
          end
        end
        PH_FW: begin
          if (whole) begin
            a_vld_next   = 1'b1;
            a_kind_next  = tqp_pkg::KIND_FW;
            a_value_next = acc_raw;
            phase_next   = PH_COUNT; bytes_left_next = 16'd4; acc_next = 64'd0;
          end
        end
        PH_COUNT: begin
          if (whole) begin
            if (acc_raw[31:0] > {27'd0, limit_eff}) begin
              a_vld_next    = 1'b1;
              a_kind_next   = tqp_pkg::KIND_ERROR;
              a_err_next    = tqp_pkg::ERR_COUNT;
              ignoring_next = 1'b1;
            end else begin
              sel_left_next   = acc_raw[4:0];
              cur_sel_next    = 4'd0;
              bytes_left_next = 16'd2;
              acc_next        = 64'd0;
              phase_next      = (acc_raw[4:0] != 5'd0) ? PH_HASH : PH_DIGEST_LEN;
            end
          end
        end
        PH_HASH: begin
          if (whole) begin
            a_vld_next   = 1'b1;
            a_kind_next  = tqp_pkg::KIND_HASH;
            a_value_next = {48'd0, len};
            r_sel_next   = cur_sel;
            phase_next   = PH_SIZEOF; bytes_left_next = 16'd1; acc_next = 64'd0;
          end
        end
        PH_SIZEOF: begin
          mask_pos_next = 8'd0;
          acc_next      = 64'd0;
          if (data_byte != 8'd0) begin
            phase_next = PH_MASK; bytes_left_next = {8'd0, data_byte};
          end else begin
            // empty mask: on to the next selection
            sel_left_next   = sel_dec;
            bytes_left_next = 16'd2;
            if (sel_dec != 5'd0) begin
              cur_sel_next = cur_sel + 4'd1;
              phase_next   = PH_HASH;
            end else begin
              phase_next = PH_DIGEST_LEN;
            end
          end
        end
        PH_MASK: begin
          r_mask_next   = data_byte;
          r_sel_next    = cur_sel;
          r_pos_next    = mask_pos;
          mask_pos_next = mask_pos + 8'd1;
          acc_next      = 64'd0;
          if (whole) begin
            sel_left_next   = sel_dec;
            bytes_left_next = 16'd2;
            if (sel_dec != 5'd0) begin
              cur_sel_next = cur_sel + 4'd1;
              phase_next   = PH_HASH;
            end else begin
              phase_next = PH_DIGEST_LEN;
            end
          end
        end
        PH_DIGEST_LEN: begin
          if (whole) begin
            if (len != 16'd0) begin
              phase_next = PH_DIGEST_BODY; bytes_left_next = len; acc_next = 64'd0;
            end else begin
              a_vld_next    = 1'b1;
              a_kind_next   = tqp_pkg::KIND_DONE;
              ignoring_next = 1'b1;
            end
          end
        end
        PH_DIGEST_BODY: begin
          a_vld_next   = 1'b1;
          a_kind_next  = tqp_pkg::KIND_DIGEST;
          a_value_next = {56'd0, data_byte};
          if (whole) begin
            t_vld_next    = 1'b1;
            t_kind_next   = tqp_pkg::KIND_DONE;
            ignoring_next = 1'b1;
          end
        end
        default: begin
          a_vld_next    = 1'b1;
          a_kind_next   = tqp_pkg::KIND_ERROR;
          a_err_next    = tqp_pkg::ERR_OVERRUN;
          ignoring_next = 1'b1;
        end
      endcase

      // buffer ended before done or failure
      if (end_of_quote && !ignoring_next) begin
        t_vld_next    = 1'b1;
        t_kind_next   = tqp_pkg::KIND_ERROR;
        t_err_next    = tqp_pkg::ERR_OVERRUN;
        ignoring_next = 1'b1;
      end
    end

    // every buffer end rearms for the next quote
    if (end_of_quote) begin
      phase_next      = PH_MAGIC;
      bytes_left_next = 16'd4;
      acc_next        = 64'd0;
      sel_left_next   = 5'd0;
      cur_sel_next    = 4'd0;
      mask_pos_next   = 8'd0;
      ignoring_next   = 1'b0;
    end
  end

  // --------------------------------------------------------------------
  // Result register drain: head, then mask bits low to high, then tail
  // --------------------------------------------------------------------
  always_comb begin
    mask_rest = r_mask & (r_mask - 8'd1);
    mask_bit  = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (r_mask[i]) mask_bit = 3'(i);
    end

    out_valid = a_vld || (r_mask != 8'd0) || t_vld;

    if (a_vld) begin
      kind            = a_kind;
      value           = a_value;
      selection_index = r_sel;
      error_code      = a_err;
      last_of_run     = (r_mask == 8'd0) && !t_vld;
    end else if (r_mask != 8'd0) begin
      kind            = tqp_pkg::KIND_PCR;
      value           = {53'd0, r_pos, mask_bit};
      selection_index = r_sel;
      error_code      = tqp_pkg::ERR_NONE;
      last_of_run     = (mask_rest == 8'd0) && !t_vld;
    end else begin
      kind            = t_kind;
      value           = 64'd0;
      selection_index = 4'd0;
      error_code      = t_err;
      last_of_run     = 1'b1;
    end

    in_ready = !out_valid || (out_ready && last_of_run);
  end

  // --------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      selection_limit <= tqp_pkg::LIMIT_RESET;
    end else if (cfg_wr_en) begin
      selection_limit <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_MAGIC;
      bytes_left <= 16'd4;
      acc        <= 64'd0;
      sel_left   <= 5'd0;
      cur_sel    <= 4'd0;
      mask_pos   <= 8'd0;
      ignoring   <= 1'b0;
    end else if (in_fire) begin
      phase      <= phase_next;
      bytes_left <= bytes_left_next;
      acc        <= acc_next;
      sel_left   <= sel_left_next;
      cur_sel    <= cur_sel_next;
      mask_pos   <= mask_pos_next;
      ignoring   <= ignoring_next;
    end
  end

  // valid bits of the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld  <= 1'b0;
      r_mask <= 8'd0;
      t_vld  <= 1'b0;
    end else if (in_fire) begin
      a_vld  <= a_vld_next;
      r_mask <= r_mask_next;
      t_vld  <= t_vld_next;
    end else if (out_fire) begin
      if (a_vld) begin
        a_vld <= 1'b0;
      end else if (r_mask != 8'd0) begin
        r_mask <= mask_rest;
      end else begin
        t_vld <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_kind  <= a_kind_next;
      a_value <= a_value_next;
      a_err   <= a_err_next;
      r_sel   <= r_sel_next;
      r_pos   <= r_pos_next;
      t_kind  <= t_kind_next;
      t_err   <= t_err_next;
    end
  end

endmodule

>>> design/tqp_checker.sv
// Port-level checks for the quote parser, bound to the top level.
`timescale 1ns / 1ps

module tqp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  data_byte,
  input logic        end_of_quote,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  kind,
  input logic [63:0] value,
  input logic [3:0]  selection_index,
  input logic [2:0]  error_code,
  input logic        last_of_run,
  input logic        cfg_wr_en,
  input logic [4:0]  cfg_wr_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(value)
      && $stable(last_of_run))
    else $error("stalled result changed");

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result present after reset");

  // done and error close the run of their byte
  a_term_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == tqp_pkg::KIND_DONE || kind == tqp_pkg::KIND_ERROR)
      |-> last_of_run)
    else $error("done or error not last of run");

  // error code only on error results
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((kind == tqp_pkg::KIND_ERROR) == (error_code != tqp_pkg::ERR_NONE)))
    else $error("error code does not match kind");

  // pcr index fits byte position and bit
  a_pcr_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == tqp_pkg::KIND_PCR |-> value[63:11] == 53'd0)
    else $error("pcr index out of range");

endmodule

bind tpm_attest_quote_parser tqp_checker u_tqp_checker (.*);

>>> sim/quote_result_checker.sv
// Checker for the quote parser: predicts the results of each accepted byte and compares them.
`timescale 1ns / 1ps

module quote_result_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_quote,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  kind,
  input  logic [63:0] value,
  input  logic [3:0]  selection_index,
  input  logic [2:0]  error_code,
  input  logic        last_of_run,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,
  output int          pending,
  output int          fail_count
);

  typedef enum logic [3:0] {
    PH_MAGIC, PH_TYPE, PH_SIGNER_LEN, PH_SIGNER_BODY, PH_NONCE_LEN, PH_NONCE_BODY,
    PH_CLOCK, PH_FW, PH_COUNT, PH_HASH, PH_SIZEOF, PH_MASK, PH_DIGEST_LEN, PH_DIGEST_BODY
  } parse_phase_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] value;
    logic [3:0]  sel;
    logic [2:0]  err;
    logic        last_flag;
  } quote_result_t;

  quote_result_t expected_results[$];
  quote_result_t byte_results[$];
  quote_result_t want;

  parse_phase_t phase;
  logic [15:0]  bytes_left;
  logic [63:0]  accum;
  logic [4:0]   sels_left;
  logic [3:0]   cur_sel;
  logic [7:0]   mask_pos;
  logic         ignoring;
  logic [4:0]   sel_limit;
  int           result_num;

  initial begin
    pending    = 0;
    fail_count = 0;
    result_num = 0;
  end

  function automatic void emit(logic [2:0] k, logic [63:0] v, logic [3:0] s, logic [2:0] e);
    quote_result_t r;
    r.kind      = k;
    r.value     = v;
    r.sel       = s;
    r.err       = e;
    r.last_flag = 1'b0;
    byte_results.insert(byte_results.size(), r);
  endfunction

  function automatic void start_field(parse_phase_t ph, logic [15:0] len);
    phase      = ph;
    bytes_left = len;
    accum      = '0;
  endfunction

  function automatic void restart_parse();
    start_field(PH_MAGIC, 16'd4);
    sels_left = '0;
    cur_sel   = '0;
    mask_pos  = '0;
    ignoring  = 1'b0;
  endfunction

  function automatic void fail_quote(logic [2:0] code);
    emit(tqp_pkg::KIND_ERROR, 64'd0, 4'd0, code);
    ignoring = 1'b1;
  endfunction

  function automatic void finish_quote();
    emit(tqp_pkg::KIND_DONE, 64'd0, 4'd0, tqp_pkg::ERR_NONE);
    ignoring = 1'b1;
  endfunction

  function automatic void next_selection();
    if (sels_left > 0) sels_left--;
    if (sels_left > 0) begin
      cur_sel++;
      start_field(PH_HASH, 16'd2);
    end else begin
      start_field(PH_DIGEST_LEN, 16'd2);
    end
  endfunction

  task automatic parse_quote_byte(input logic [7:0] b, input logic eoq);
    logic          whole;
    logic [15:0]   len;
    logic [4:0]    limit;
    logic [3:0]    bit_idx;
    quote_result_t r;
    int            i;
    byte_results.delete();
    if (!ignoring) begin
      accum = {accum[55:0], b};
      if (bytes_left > 0) bytes_left--;
      whole = (bytes_left == 0);
      len   = accum[15:0];
      case (phase)
        PH_MAGIC: if (whole) begin
          if (accum[31:0] != tqp_pkg::MAGIC_WORD) fail_quote(tqp_pkg::ERR_MAGIC);
          else start_field(PH_TYPE, 16'd2);
        end
        PH_TYPE: if (whole) begin
          if (len != tqp_pkg::QUOTE_TYPE) fail_quote(tqp_pkg::ERR_TYPE);
          else start_field(PH_SIGNER_LEN, 16'd2);
        end
        PH_SIGNER_LEN: if (whole) begin
          if (len != 0) start_field(PH_SIGNER_BODY, len);
          else start_field(PH_NONCE_LEN, 16'd2);
        end
        PH_SIGNER_BODY: if (whole) start_field(PH_NONCE_LEN, 16'd2);
        PH_NONCE_LEN: if (whole) begin
          if (len != 0) start_field(PH_NONCE_BODY, len);
          else start_field(PH_CLOCK, tqp_pkg::CLOCK_BYTES);
        end
        PH_NONCE_BODY: begin
          emit(tqp_pkg::KIND_NONCE, {56'd0, b}, 4'd0, tqp_pkg::ERR_NONE);
          if (whole) start_field(PH_CLOCK, tqp_pkg::CLOCK_BYTES);
        end
        PH_CLOCK: if (whole) start_field(PH_FW, 16'd8);
        PH_FW: if (whole) begin
          emit(tqp_pkg::KIND_FW, accum, 4'd0, tqp_pkg::ERR_NONE);
          start_field(PH_COUNT, 16'd4);
        end
        PH_COUNT: if (whole) begin
          limit = (sel_limit < tqp_pkg::MAX_SELECTIONS) ? sel_limit : tqp_pkg::MAX_SELECTIONS;
          if (accum[31:0] > {27'd0, limit}) begin
            fail_quote(tqp_pkg::ERR_COUNT);
          end else begin
            sels_left = accum[4:0];
            cur_sel   = '0;
            if (accum[4:0] != 0) start_field(PH_HASH, 16'd2);
            else start_field(PH_DIGEST_LEN, 16'd2);
          end
        end
        PH_HASH: if (whole) begin
          emit(tqp_pkg::KIND_HASH, {48'd0, len}, cur_sel, tqp_pkg::ERR_NONE);
          start_field(PH_SIZEOF, 16'd1);
        end
        PH_SIZEOF: begin
          mask_pos = '0;
          if (b != 0) start_field(PH_MASK, {8'd0, b});
          else next_selection();
        end
        PH_MASK: begin
          // one pcr result per set bit, lowest bit first
          for (bit_idx = 0; bit_idx < 8; bit_idx++)
            if (b[bit_idx[2:0]])
              emit(tqp_pkg::KIND_PCR, {53'd0, mask_pos, bit_idx[2:0]}, cur_sel,
                   tqp_pkg::ERR_NONE);
          mask_pos++;
          if (whole) next_selection();
          else accum = '0;
        end
        PH_DIGEST_LEN: if (whole) begin
          if (len != 0) start_field(PH_DIGEST_BODY, len);
          else finish_quote();
        end
        PH_DIGEST_BODY: begin
          emit(tqp_pkg::KIND_DIGEST, {56'd0, b}, 4'd0, tqp_pkg::ERR_NONE);
          if (whole) finish_quote();
        end
        default: fail_quote(tqp_pkg::ERR_OVERRUN);
      endcase
      // buffer ended before the quote was done or failed
      if (eoq && !ignoring) fail_quote(tqp_pkg::ERR_OVERRUN);
    end
    if (eoq) restart_parse();
    for (i = 0; i < byte_results.size(); i++) begin
      r = byte_results[i];
      r.last_flag = (i == byte_results.size() - 1);
      expected_results.insert(expected_results.size(), r);
    end
  endtask

  task automatic report(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] exp_val);
    if (got !== exp_val)
      report($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                       result_num, name, got, exp_val));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      restart_parse();
      sel_limit = tqp_pkg::LIMIT_RESET;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report($sformatf("result %0d arrived with none expected (kind %0d)", result_num, kind));
        end else begin
          want = expected_results.pop_front();
          check_field("kind", 64'(kind), 64'(want.kind));
          check_field("value", value, want.value);
          check_field("selection_index", 64'(selection_index), 64'(want.sel));
          check_field("error_code", 64'(error_code), 64'(want.err));
          check_field("last_of_run", 64'(last_of_run), 64'(want.last_flag));
        end
        result_num++;
      end
      if (in_valid && in_ready) parse_quote_byte(data_byte, end_of_quote);
      if (cfg_wr_en) sel_limit = cfg_wr_data;
    end
    pending = expected_results.size();
  end

endmodule

>>> sim/tb_tpm_attest_quote_parser.sv
// Testbench top for the quote parser: builds quote byte streams, randomizes stalls, gives the verdict.
`timescale 1ns / 1ps

module tb_tpm_attest_quote_parser;

  // Run length. Worst case per item is a sender gap plus 9 results that each
  // wait out a receiver stall; the limit leaves plenty of margin.
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int TARGET_BYTES = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int SETTLE_CYCLES = 4;     // quiet wait before a limit write
  localparam logic [4:0] LIMIT_TOP = 5'd31;  // above MAX_SELECTIONS, gets clamped

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        end_of_quote;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  kind;
  logic [63:0] value;
  logic [3:0]  selection_index;
  logic [2:0]  error_code;
  logic        last_of_run;
  logic        cfg_wr_en;
  logic [4:0]  cfg_wr_data;

  int pending;
  int fail_count;
  int cycle_count;

  // Stream under construction; sent as one buffer with end_of_quote on the last byte.
  logic [7:0] quote_bytes[$];
  int         cfg_point;        // byte index before which the limit is rewritten, -1 = none
  logic [4:0] cfg_point_value;
  logic [4:0] cur_limit;        // generator's view of selection_limit
  logic       no_idle_in;
  logic       no_idle_out;
  int         bytes_sent;

  tpm_attest_quote_parser dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .data_byte       (data_byte),
    .end_of_quote    (end_of_quote),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .kind            (kind),
    .value           (value),
    .selection_index (selection_index),
    .error_code      (error_code),
    .last_of_run     (last_of_run),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  quote_result_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .data_byte       (data_byte),
    .end_of_quote    (end_of_quote),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .kind            (kind),
    .value           (value),
    .selection_index (selection_index),
    .error_code      (error_code),
    .last_of_run     (last_of_run),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .pending         (pending),
    .fail_count      (fail_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog: a hung handshake ends the run here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[%0t] timeout after %0d cycles", $time, cycle_count);
    $display("== FAIL ==");
    $finish;
  end

  // Wait before each item; a no-idle stretch forces back-to-back traffic.
  function automatic int draw_gap(logic no_idle);
    return no_idle ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic logic [4:0] pick_limit();
    logic [4:0] v;
    case ($urandom_range(0, 5))
      0:       v = 5'd0;
      1:       v = tqp_pkg::MAX_SELECTIONS;
      2:       v = LIMIT_TOP;
      3:       v = 5'd1;
      default: v = 5'($urandom_range(0, 31));
    endcase
    return v;
  endfunction

  // Mask bytes: empty, full, one bit, or anything.
  function automatic logic [7:0] draw_mask();
    logic [7:0] m;
    case ($urandom_range(0, 3))
      0:       m = 8'h00;
      1:       m = 8'hFF;
      2:       m = 8'h01 << $urandom_range(0, 7);
      default: m = 8'($urandom_range(0, 255));
    endcase
    return m;
  endfunction

  // Append one byte to the stream.
  function automatic void add_byte(logic [7:0] b);
    quote_bytes.insert(quote_bytes.size(), b);
  endfunction

  // Big-endian field of n bytes.
  function automatic void push_be(logic [63:0] v, int n);
    int i;
    for (i = n - 1; i >= 0; i--) add_byte(v[8*i +: 8]);
  endfunction

  function automatic void push_random(int n);
    repeat (n) add_byte(8'($urandom_range(0, 255)));
  endfunction

  // Everything up to and including the firmware version.
  function automatic void push_header(int signer_len, int nonce_len);
    push_be(64'(tqp_pkg::MAGIC_WORD), 4);
    push_be(64'(tqp_pkg::QUOTE_TYPE), 2);
    push_be(64'(signer_len), 2);
    push_random(signer_len);
    push_be(64'(nonce_len), 2);
    push_random(nonce_len);
    push_random(int'(tqp_pkg::CLOCK_BYTES));
    push_be({$urandom, $urandom}, 8);
  endfunction

  function automatic void push_selection();
    int m;
    m = $urandom_range(0, 4);
    push_be(64'($urandom), 2);
    push_be(64'(m), 1);
    repeat (m) add_byte(draw_mask());
  endfunction

  function automatic void push_digest(int len);
    push_be(64'(len), 2);
    push_random(len);
  endfunction

  // Well-formed quote with random content; selection count fits the limit
  // as seen now. Sometimes the limit is rewritten just before the count.
  function automatic void build_good_quote();
    int eff;
    int n;
    eff = int'((cur_limit > tqp_pkg::MAX_SELECTIONS) ? tqp_pkg::MAX_SELECTIONS : cur_limit);
    push_header(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4), $urandom_range(0, 5));
    if ($urandom_range(0, 7) == 0) n = $urandom_range(0, eff);
    else n = $urandom_range(0, (eff < 3) ? eff : 3);
    if ($urandom_range(0, 7) == 0) begin
      cfg_point       = quote_bytes.size();
      cfg_point_value = pick_limit();
    end
    push_be(64'(n), 4);
    repeat (n) push_selection();
    push_digest(($urandom_range(0, 7) == 0) ? 32 : $urandom_range(0, 6));
  endfunction

  // Limit writes happen only with the parser drained: nothing expected and
  // a few quiet cycles for a byte that produced no result.
  task automatic write_limit(input logic [4:0] v);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cur_limit = v;
  endtask

  // One input item; valid stays up until the item is taken.
  task automatic send_byte(input logic [7:0] b, input logic eoq);
    int gap;
    gap = draw_gap(no_idle_in);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    data_byte    <= b;
    end_of_quote <= eoq;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_quote();
    int i;
    no_idle_in = ($urandom_range(0, 3) == 0);
    for (i = 0; i < quote_bytes.size(); i++) begin
      if (i == cfg_point) write_limit(cfg_point_value);
      send_byte(quote_bytes[i], i == quote_bytes.size() - 1);
      bytes_sent++;
    end
    quote_bytes.delete();
    cfg_point = -1;
  endtask

  // Receiver: random stall before each result item, with no-stall stretches.
  initial begin
    int gap;
    int taken;
    out_ready   = 1'b0;
    no_idle_out = 1'b0;
    taken       = 0;
    wait (!rst);
    forever begin
      if (taken % 32 == 0) no_idle_out = ($urandom_range(0, 3) == 0);
      gap = draw_gap(no_idle_out);
      @(negedge clk);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  initial begin
    int r;
    int idx;
    int keep;
    int eff;
    rst          = 1'b1;
    in_valid     = 1'b0;
    data_byte    = 8'd0;
    end_of_quote = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = 5'd0;
    cur_limit    = tqp_pkg::LIMIT_RESET;
    cfg_point    = -1;
    no_idle_in   = 1'b0;
    bytes_sent   = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // ---- directed ----
    // Magic off by one bit, buffer ends on the last magic byte: magic error only.
    push_be(64'(tqp_pkg::MAGIC_WORD ^ 32'h1), 4);
    send_quote();
    // Wrong type, top bit cleared.
    push_be(64'(tqp_pkg::MAGIC_WORD), 4);
    push_be(64'(tqp_pkg::QUOTE_TYPE ^ 16'h8000), 2);
    send_quote();
    // Limit 0: shortest legal quote, all fields empty, zero selections;
    // done comes on the digest length, trailing bytes are ignored.
    write_limit(5'd0);
    push_header(0, 0);
    push_be(64'd0, 4);
    push_digest(0);
    push_random(3);
    send_quote();
    // Count one against limit 0: count error, rest ignored.
    push_header(1, 1);
    push_be(64'd1, 4);
    push_random(2);
    send_quote();
    // Limit above the maximum clamps to 16. Full quote with a full mask,
    // an empty mask, a mixed mask and an empty selection.
    write_limit(LIMIT_TOP);
    push_header(2, 3);
    push_be(64'd2, 4);
    push_be(64'h000B, 2);
    push_be(64'd3, 1);
    add_byte(8'hFF);
    add_byte(8'h00);
    add_byte(8'h81);
    push_be(64'hFFFF, 2);
    push_be(64'd0, 1);
    push_digest(4);
    send_quote();
    // Buffer ends on an all-ones mask byte: eight pcr results plus overrun.
    push_header(0, 0);
    push_be(64'd1, 4);
    push_be(64'h0004, 2);
    push_be(64'd2, 1);
    add_byte(8'hFF);
    send_quote();
    // Exactly at the limit of 16 selections, then one over.
    write_limit(tqp_pkg::MAX_SELECTIONS);
    push_header(0, 0);
    push_be(64'd16, 4);
    repeat (16) begin
      push_be(64'($urandom), 2);
      push_be(64'd0, 1);
    end
    push_digest(0);
    send_quote();
    push_header(0, 0);
    push_be(64'd17, 4);
    send_quote();
    // Huge signer length cut short: overrun while skipping.
    push_be(64'(tqp_pkg::MAGIC_WORD), 4);
    push_be(64'(tqp_pkg::QUOTE_TYPE), 2);
    push_be(64'hFFFF, 2);
    push_random(3);
    send_quote();
    // Buffer of a single byte.
    add_byte(8'hFF);
    send_quote();

    // ---- random ----
    while (bytes_sent < TARGET_BYTES) begin
      if ($urandom_range(0, 4) == 0) write_limit(pick_limit());
      r = $urandom_range(0, 99);
      if (r < 60) begin
        // well-formed, sometimes with trailing bytes
        build_good_quote();
        if ($urandom_range(0, 3) == 0) push_random($urandom_range(1, 4));
      end else if (r < 75) begin
        // well-formed but the buffer ends early
        build_good_quote();
        keep = $urandom_range(1, quote_bytes.size());
        while (quote_bytes.size() > keep) quote_bytes.delete(quote_bytes.size() - 1);
      end else if (r < 85) begin
        // one flipped bit somewhere
        build_good_quote();
        idx = $urandom_range(0, quote_bytes.size() - 1);
        quote_bytes[idx] = quote_bytes[idx] ^ (8'h01 << $urandom_range(0, 7));
      end else if (r < 90) begin
        // selection count above the limit
        eff = int'((cur_limit > tqp_pkg::MAX_SELECTIONS) ? tqp_pkg::MAX_SELECTIONS : cur_limit);
        push_header($urandom_range(0, 2), $urandom_range(0, 2));
        if ($urandom_range(0, 1) == 0) push_be(64'(eff + 1), 4);
        else push_be(64'($urandom), 4);
        push_random($urandom_range(0, 4));
      end else if (r < 95) begin
        // large length field, buffer cut a few bytes into the body
        case ($urandom_range(0, 2))
          0: begin
            push_be(64'(tqp_pkg::MAGIC_WORD), 4);
            push_be(64'(tqp_pkg::QUOTE_TYPE), 2);
            push_be(64'($urandom_range(16, 65535)), 2);
          end
          1: begin
            push_be(64'(tqp_pkg::MAGIC_WORD), 4);
            push_be(64'(tqp_pkg::QUOTE_TYPE), 2);
            push_be(64'd0, 2);
            push_be(64'($urandom_range(16, 65535)), 2);
          end
          default: begin
            push_header(0, 0);
            push_be(64'd0, 4);
            push_be(64'($urandom_range(16, 65535)), 2);
          end
        endcase
        push_random($urandom_range(0, 5));
      end else begin
        // noise
        push_random($urandom_range(1, 12));
      end
      send_quote();
    end

    // ---- drain and verdict ----
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
